[design/range_assign_max_skyline_unit_macros.svh]
// Assertion macros for the range assign / range max skyline unit.
// Included by the top level; needs nothing else.
`ifndef RANGE_ASSIGN_MAX_SKYLINE_UNIT_MACROS_SVH
`define RANGE_ASSIGN_MAX_SKYLINE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define RASU_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define RASU_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RASU_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define RASU_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

[design/rasu_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the skyline unit.
// No dependencies.
package rasu_pkg;

    localparam int POS_W    = 11;
    localparam int END_W    = POS_W + 1;
    localparam int HEIGHT_W = 32;
    localparam int SUM_W    = HEIGHT_W + 1;

    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [END_W-1:0]    end_t;
    typedef logic [HEIGHT_W-1:0] height_t;
    typedef logic [SUM_W-1:0]    sum_t;

    localparam logic    REQ_DROP   = 1'b0;
    localparam logic    REQ_QUERY  = 1'b1;
    localparam pos_t    COLS_RESET = 11'd1024;
    localparam end_t    POS_MAX    = END_W'((1 << POS_W) - 1);
    localparam height_t HEIGHT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic clear_acc;
        logic acc_en;
        logic rd_en;
        logic wr_en;
        logic clear_valid;
        logic set_valid;
    } cell_ctl_t;

endpackage

[design/rasu_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels of the skyline unit: request in, result out.
// Depends on rasu_pkg.
interface rasu_req_if;
    import rasu_pkg::*;

    logic valid;
    logic ready;
    logic req_type;
    pos_t first_pos;
    pos_t second_arg;

    modport source (output valid, req_type, first_pos, second_arg, input ready);
    modport sink   (input valid, req_type, first_pos, second_arg, output ready);
endinterface

interface rasu_rsp_if;
    import rasu_pkg::*;

    logic    valid;
    logic    ready;
    height_t max_height;

    modport source (output valid, max_height, input ready);
    modport sink   (input valid, max_height, output ready);
endinterface

[design/rasu_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rasu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/rasu_cell.sv]
`timescale 1ns / 1ps
// One cell of the skyline chain: a slice of columns in RAM, local max, chain stage.
// Depends on rasu_pkg and rasu_ram.
module rasu_cell #(
    parameter int CELL_ID   = 0,
    parameter int DEPTH_LOG = 5,
    parameter int COL_W     = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rasu_pkg::cell_ctl_t  ctl,
    input  logic [DEPTH_LOG-1:0] addr,
    input  logic [DEPTH_LOG-1:0] addr_d,
    input  rasu_pkg::pos_t       lo,
    input  rasu_pkg::end_t       span_end,
    input  rasu_pkg::height_t    key,
    input  rasu_pkg::height_t    chain_in,
    output rasu_pkg::height_t    chain_out
);
    import rasu_pkg::*;

    localparam int DEPTH = 1 << DEPTH_LOG;
    localparam int CMP_W = (COL_W > END_W) ? COL_W : END_W;
    localparam logic [CMP_W-1:0] BASE = CMP_W'(CELL_ID * DEPTH);

    logic             valid_reg;
    height_t          local_max_reg;
    height_t          chain_reg;
    height_t          rd_data;
    height_t          wr_data;
    logic             wr_en;
    logic [CMP_W-1:0] col_rd;
    logic [CMP_W-1:0] col_wr;
    logic             rd_hit;
    logic             wr_hit;

    assign col_rd = BASE + CMP_W'(addr_d);
    assign col_wr = BASE + CMP_W'(addr);
    assign rd_hit = (col_rd >= CMP_W'(lo)) && (col_rd < CMP_W'(span_end));
    assign wr_hit = (col_wr >= CMP_W'(lo)) && (col_wr < CMP_W'(span_end));

    // a slice never written reads as zero; its first drop fills every entry
    assign wr_en   = ctl.wr_en && (wr_hit || !valid_reg);
    assign wr_data = wr_hit ? key : '0;

    rasu_ram #(
        .WIDTH(HEIGHT_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(addr),
        .wr_data(wr_data),
        .rd_en  (ctl.rd_en),
        .rd_addr(addr),
        .rd_data(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.clear_valid)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.set_valid)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear_acc)
        begin
            local_max_reg <= '0;
        end
        else if (ctl.acc_en && rd_hit && valid_reg && (rd_data > local_max_reg))
        begin
            local_max_reg <= rd_data;
        end
        chain_reg <= (chain_in > local_max_reg) ? chain_in : local_max_reg;
    end

    assign chain_out = chain_reg;

endmodule

[design/range_assign_max_skyline_unit.sv]
`timescale 1ns / 1ps
// Skyline unit: column heights with range max queries and range raising drops.
// Depends on rasu_pkg, rasu_if, rasu_cell, rasu_ram and the assertion macros.
//
// req (valid/ready) carries one item: req_type 0 is a drop at first_pos with
// width second_arg, req_type 1 a max query from column first_pos to second_arg.
// A query gives one item on rsp (max_height); a drop gives none.
// cfg_wr_en/cfg_wr_data write columns_in_use and clear all heights.
// Columns sit in a row of CELLS cells of DEPTH entries each (32 x 32 at 1024
// columns). Every cell scans its RAM slice entry by entry; the slice maxima
// then ripple down the cell chain, one cell per cycle.
// Query: the result is loaded into the output register at the end; the next
// item is taken only once the unit is back in idle.
// Drop: a second write sweep over every slice follows the reduce; the next
// item is taken only after that sweep.
// Reset clears all heights through per-cell valid bits at once, so items are
// taken right after reset; columns_in_use resets to 1024.
// A stalled result sits in the output register; the next item is accepted and
// processed, and only its own result waits for the register to free up.
`include "range_assign_max_skyline_unit_macros.svh"
module range_assign_max_skyline_unit #(
    parameter int COLUMNS = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    rasu_req_if.sink       req,
    rasu_rsp_if.source     rsp,
    input  logic           cfg_wr_en,
    input  rasu_pkg::pos_t cfg_wr_data
);
    import rasu_pkg::*;

    localparam int COL_LOG   = (COLUMNS > 1) ? $clog2(COLUMNS) : 0;
    localparam int DEPTH_LOG = (((COL_LOG + 1) / 2) > 1) ? ((COL_LOG + 1) / 2) : 1;
    localparam int DEPTH     = 1 << DEPTH_LOG;
    localparam int CELLS     = (COLUMNS + DEPTH - 1) / DEPTH;
    localparam int COL_W     = $clog2(CELLS * DEPTH);
    localparam int RED_W     = $clog2(CELLS + 1);

    localparam logic [DEPTH_LOG-1:0] IDX_LAST = DEPTH_LOG'(DEPTH - 1);
    localparam logic [RED_W-1:0]     RED_LAST = RED_W'(CELLS);
    localparam end_t COLS_CAP = (COLUMNS > (1 << POS_W) - 1) ? POS_MAX : END_W'(COLUMNS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_REDUCE = 3'd2;
    localparam logic [2:0] ST_KEY    = 3'd3;
    localparam logic [2:0] ST_WRITE  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [DEPTH_LOG-1:0] idx_reg, idx_next;
    logic [RED_W-1:0]     red_cnt_reg, red_cnt_next;
    logic                 acc_en_reg;
    logic [DEPTH_LOG-1:0] addr_d_reg;
    logic                 type_reg;
    logic                 rsp_valid_reg, rsp_valid_next;
    pos_t                 cfg_reg;
    pos_t                 lo_reg;
    end_t                 span_end_reg;
    pos_t                 width_reg;
    height_t              key_reg;
    height_t              rsp_data_reg;

    logic      accept;
    logic      rsp_load;
    end_t      n_cols;
    end_t      raw_end;
    end_t      span_end_in;
    pos_t      lo_in;
    sum_t      key_sum;
    height_t   key_sat;
    cell_ctl_t ctl;
    height_t   chain_w [CELLS+1];

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign n_cols      = (END_W'(cfg_reg) > COLS_CAP) ? COLS_CAP : END_W'(cfg_reg);
    assign raw_end     = (req.req_type == REQ_DROP)
                         ? END_W'(req.first_pos) + END_W'(req.second_arg)
                         : END_W'(req.second_arg);
    assign span_end_in = (raw_end > n_cols) ? n_cols : raw_end;
    assign lo_in       = (req.first_pos == '0) ? '0 : req.first_pos - POS_W'(1);

    assign key_sum = SUM_W'(chain_w[CELLS]) + SUM_W'(width_reg);
    assign key_sat = key_sum[HEIGHT_W] ? HEIGHT_MAX : key_sum[HEIGHT_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        red_cnt_next    = red_cnt_reg;
        rsp_load        = 1'b0;
        ctl             = '0;
        ctl.clear_acc   = accept;
        ctl.acc_en      = acc_en_reg;
        ctl.clear_valid = cfg_wr_en;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                end
            end
            ST_SCAN:
            begin
                ctl.rd_en = 1'b1;
                idx_next  = idx_reg + DEPTH_LOG'(1);
                if (idx_reg == IDX_LAST)
                begin
                    state_next   = ST_REDUCE;
                    red_cnt_next = '0;
                end
            end
            ST_REDUCE:
            begin
                red_cnt_next = red_cnt_reg + RED_W'(1);
                if (red_cnt_reg == RED_LAST)
                begin
                    state_next = (type_reg == REQ_DROP) ? ST_KEY : ST_DONE;
                end
            end
            ST_KEY:
            begin
                state_next = ST_WRITE;
                idx_next   = '0;
            end
            ST_WRITE:
            begin
                ctl.wr_en = 1'b1;
                idx_next  = idx_reg + DEPTH_LOG'(1);
                if (idx_reg == IDX_LAST)
                begin
                    ctl.set_valid = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            red_cnt_reg   <= '0;
            acc_en_reg    <= 1'b0;
            type_reg      <= REQ_DROP;
            rsp_valid_reg <= 1'b0;
            cfg_reg       <= COLS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            red_cnt_reg   <= red_cnt_next;
            acc_en_reg    <= (state_reg == ST_SCAN);
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                type_reg <= req.req_type;
            end
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_d_reg <= idx_reg;
        if (accept)
        begin
            lo_reg       <= lo_in;
            span_end_reg <= span_end_in;
            width_reg    <= req.second_arg;
        end
        if (state_reg == ST_KEY)
        begin
            key_reg <= key_sat;
        end
        if (rsp_load)
        begin
            rsp_data_reg <= chain_w[CELLS];
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.max_height = rsp_data_reg;

    assign chain_w[0] = '0;

    for (genvar gi = 0; gi < CELLS; gi++)
    begin : g_cell
        rasu_cell #(
            .CELL_ID  (gi),
            .DEPTH_LOG(DEPTH_LOG),
            .COL_W    (COL_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .addr     (idx_reg),
            .addr_d   (addr_d_reg),
            .lo       (lo_reg),
            .span_end (span_end_reg),
            .key      (key_reg),
            .chain_in (chain_w[gi]),
            .chain_out(chain_w[gi+1])
        );
    end

    `RASU_ASSERT(a_write_only_drop, clk, rst_n, (state_reg == ST_WRITE) |-> (type_reg == REQ_DROP), "write sweep outside a drop")
    `RASU_ASSERT(a_reduce_align, clk, rst_n, (state_reg == ST_REDUCE && red_cnt_reg == '0) |-> acc_en_reg, "last scan entry not in flight at reduce start")
    `RASU_ASSERT(a_rsp_from_query, clk, rst_n, (rsp_valid_reg && !$past(rsp_valid_reg)) |-> ($past(state_reg) == ST_DONE && $past(type_reg) == REQ_QUERY), "result item not from a query")
    `RASU_ASSERT_NEXT(a_key_then_write, clk, rst_n, state_reg == ST_KEY, state_reg == ST_WRITE && idx_reg == '0, "write sweep did not start at entry zero")

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for range_assign_max_skyline_unit: a directed table, then random
// drops and queries over several column counts, checked against a per-column height array.
// Depends on rasu_pkg, rasu_if and the unit itself.
module testbench;
    import rasu_pkg::*;

    localparam int COLUMNS      = 1024;
    localparam int DRAIN_CYCLES = 150;
    localparam int PHASE_ITEMS  = 200;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        logic      rtype;
        pos_t      first;
        pos_t      second;
        logic      typed;
        height_t   want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    pos_t cfg_wr_data;

    rasu_req_if req_ch ();
    rasu_rsp_if rsp_ch ();

    range_assign_max_skyline_unit #(
        .COLUMNS(COLUMNS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    height_t col_height [0:COLUMNS-1];
    int      live_cols;
    height_t query_heights [$];
    int      mismatches = 0;
    bit      req_rush = 1'b0;
    bit      rsp_rush = 1'b0;

    pos_t phase_cols [0:7] = '{11'd1024, 11'd3, 11'd40, 11'd2047,
                               11'd1, 11'd100, 11'd0, 11'd513};

    // empty: l > r, r = 0, start past the last column; zero columns; write clears
    plan_row_t opening_rows [0:29] = '{
        '{ROW_REQ, REQ_QUERY, 11'd1,    11'd1024, 1'b1, 32'd0},
        '{ROW_REQ, REQ_QUERY, 11'd0,    11'd2047, 1'b1, 32'd0},
        '{ROW_REQ, REQ_DROP,  11'd0,    11'd2047, 1'b0, 32'd0},
        '{ROW_REQ, REQ_QUERY, 11'd1,    11'd1,    1'b1, 32'd2047},
        '{ROW_REQ, REQ_QUERY, 11'd1024, 11'd1024, 1'b1, 32'd2047},
        '{ROW_REQ, REQ_DROP,  11'd1,    11'd0,    1'b0, 32'd0},
        '{ROW_REQ, REQ_DROP,  11'd1024, 11'd2047, 1'b0, 32'd0},
        '{ROW_REQ, REQ_QUERY, 11'd1,    11'd1024, 1'b1, 32'd4094},
        '{ROW_REQ, REQ_DROP,  11'd10,   11'd5,    1'b0, 32'd0},
        '{ROW_REQ, REQ_QUERY, 11'd9,    11'd16,   1'b0, 32'd0},
        '{ROW_REQ, REQ_QUERY, 11'd6,    11'd3,    1'b1, 32'd0},
        '{ROW_REQ, REQ_QUERY, 11'd5,    11'd0,    1'b1, 32'd0},
        '{ROW_REQ, REQ_QUERY, 11'd1025, 11'd2047, 1'b1, 32'd0},
        '{ROW_REQ, REQ_DROP,  11'd2047, 11'd5,    1'b0, 32'd0},
        '{ROW_REQ, REQ_QUERY, 11'd0,    11'd0,    1'b1, 32'd0},
        '{ROW_CFG, REQ_DROP,  11'd0,    11'd0,    1'b0, 32'd0},
        '{ROW_REQ, REQ_QUERY, 11'd1,    11'd1024, 1'b1, 32'd0},
        '{ROW_REQ, REQ_DROP,  11'd1,    11'd10,   1'b0, 32'd0},
        '{ROW_REQ, REQ_QUERY, 11'd0,    11'd2047, 1'b1, 32'd0},
        '{ROW_CFG, REQ_DROP,  11'd1,    11'd0,    1'b0, 32'd0},
        '{ROW_REQ, REQ_DROP,  11'd0,    11'd2047, 1'b0, 32'd0},
        '{ROW_REQ, REQ_QUERY, 11'd1,    11'd2047, 1'b1, 32'd2047},
        '{ROW_REQ, REQ_DROP,  11'd2,    11'd3,    1'b0, 32'd0},
        '{ROW_REQ, REQ_QUERY, 11'd1,    11'd1,    1'b1, 32'd2047},
        '{ROW_CFG, REQ_DROP,  11'd2047, 11'd0,    1'b0, 32'd0},
        '{ROW_REQ, REQ_QUERY, 11'd1,    11'd2047, 1'b1, 32'd0},
        '{ROW_REQ, REQ_DROP,  11'd1000, 11'd100,  1'b0, 32'd0},
        '{ROW_REQ, REQ_QUERY, 11'd1024, 11'd1024, 1'b1, 32'd100},
        '{ROW_REQ, REQ_QUERY, 11'd999,  11'd999,  1'b0, 32'd0},
        '{ROW_CFG, REQ_DROP,  11'd1024, 11'd0,    1'b0, 32'd0}
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic height_t peak_over(input int a, input int b);
        height_t peak;
        int lo;
        int hi;
        peak = '0;
        lo = (a < 0) ? 0 : a;
        hi = (b > live_cols - 1) ? live_cols - 1 : b;
        for (int c = lo; c <= hi; c++)
        begin
            if (col_height[c] > peak)
                peak = col_height[c];
        end
        return peak;
    endfunction

    function automatic void drop_block(input int a, input int b, input int width);
        sum_t raised;
        int lo;
        int hi;
        raised = sum_t'(peak_over(a, b)) + sum_t'(width);
        if (raised > sum_t'(HEIGHT_MAX))
            raised = sum_t'(HEIGHT_MAX);
        lo = (a < 0) ? 0 : a;
        hi = (b > live_cols - 1) ? live_cols - 1 : b;
        for (int c = lo; c <= hi; c++)
            col_height[c] = height_t'(raised);
    endfunction

    function automatic void clear_skyline(input pos_t cols);
        live_cols = (int'(cols) > COLUMNS) ? COLUMNS : int'(cols);
        foreach (col_height[c])
            col_height[c] = '0;
    endfunction

    function automatic void draw_request(output logic rtype, output pos_t first,
                                         output pos_t second);
        int n;
        int pick;
        n = (live_cols == 0) ? 1 : live_cols;
        rtype = ($urandom_range(0, 1) == 0) ? REQ_DROP : REQ_QUERY;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            first = pos_t'($urandom);
            second = pos_t'($urandom);
        end
        else if (rtype == REQ_DROP)
        begin
            first = pos_t'($urandom_range(0, n + 1));
            second = (pick < 8) ? pos_t'($urandom_range(0, 8)) : pos_t'($urandom_range(0, n));
        end
        else
        begin
            first = pos_t'($urandom_range(0, n + 1));
            if (pick == 9)
                second = pos_t'($urandom_range(0, n + 1));
            else
                second = pos_t'($urandom_range(int'(first), n + 1));
        end
    endfunction

    task automatic send_request(input logic rtype, input pos_t first, input pos_t second,
                                input logic typed, input height_t want);
        int      gap;
        height_t predicted;
        if ($urandom_range(0, 31) == 0)
            req_rush = !req_rush;
        gap = req_rush ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= rtype;
        req_ch.first_pos  <= first;
        req_ch.second_arg <= second;
        do @(posedge clk); while (!req_ch.ready);
        if (rtype == REQ_QUERY)
        begin
            predicted = typed ? want : peak_over(int'(first) - 1, int'(second) - 1);
            query_heights = {query_heights, predicted};
        end
        else
            drop_block(int'(first) - 1, int'(first) - 1 + int'(second), int'(second));
    endtask

    // drops leave nothing to wait on, so allow a full drop time after the last result
    task automatic wait_quiet();
        req_ch.valid <= 1'b0;
        while (query_heights.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_columns(input pos_t cols);
        wait_quiet();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cols;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        clear_skyline(cols);
    endtask

    initial
    begin
        logic rt;
        pos_t fp;
        pos_t sa;
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_DROP;
        req_ch.first_pos  <= '0;
        req_ch.second_arg <= '0;
        clear_skyline(COLS_RESET);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_rows[i])
        begin
            if (opening_rows[i].kind == ROW_CFG)
                write_columns(opening_rows[i].first);
            else
                send_request(opening_rows[i].rtype, opening_rows[i].first,
                             opening_rows[i].second, opening_rows[i].typed,
                             opening_rows[i].want);
        end

        foreach (phase_cols[ph])
        begin
            write_columns((phase_cols[ph] == 11'd0) ? pos_t'($urandom_range(2, 2047))
                                                   : phase_cols[ph]);
            repeat (PHASE_ITEMS)
            begin
                draw_request(rt, fp, sa);
                send_request(rt, fp, sa, 1'b0, '0);
            end
        end

        wait_quiet();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                rsp_rush = !rsp_rush;
            stall = rsp_rush ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (query_heights.size() == 0)
            begin
                $display("%0t: unexpected max_height, expected none, actual %0d",
                         $time, rsp_ch.max_height);
                mismatches++;
            end
            else
            begin
                if (rsp_ch.max_height !== query_heights[0])
                begin
                    $display("%0t: max_height mismatch, expected %0d, actual %0d",
                             $time, query_heights[0], rsp_ch.max_height);
                    mismatches++;
                end
                void'(query_heights.pop_front());
            end
        end
    end

    initial
    begin
        #12_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[range_assign_max_skyline_unit.f]
+incdir+design
design/rasu_pkg.sv
design/rasu_if.sv
design/rasu_ram.sv
design/rasu_cell.sv
design/range_assign_max_skyline_unit.sv
dv/testbench.sv
